FILE: rtl/core/pngse_pkg.sv
package pngse_pkg;

    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int PIX_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 2 * CFG_W + 2;
    localparam int DEF_MAX_DIM = 4096;
    localparam int DEF_ITEM_DEPTH = 2;
    localparam int DEF_OUT_DEPTH  = 2;

    localparam int MIN_WIDTH     = 2;
    localparam int BLOCK_MAX     = 65535;
    localparam int ADLER_MOD     = 65521;
    localparam int IDAT_OVERHEAD = 6;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    localparam logic [7:0] ZLIB_CMF   = 8'h78;
    localparam logic [7:0] ZLIB_FLG   = 8'h01;
    localparam logic [7:0] IHDR_LEN   = 8'd13;
    localparam logic [7:0] BIT_DEPTH  = 8'd8;
    localparam logic [7:0] COLOR_RGBA = 8'd6;

    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_N = 8'h4E;

    localparam logic [7:0] SIG_BYTES [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                             8'h0D, 8'h0A, 8'h1A, 8'h0A};

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             start;
        logic             col0;
        logic             done;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              eof;
    } out_t;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [RAW_W-1:0] raw_len;
        logic [31:0]      idat_len;
    } geom_t;

endpackage

FILE: rtl/core/pngse_fifo.sv
module pngse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             wr_en, rd_en;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/pngse_front.sv
module pngse_front #(
    parameter int MAX_DIM = pngse_pkg::DEF_MAX_DIM
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic [pngse_pkg::PIX_W-1:0]         pixel,
    input  logic                                cfg_we,
    input  logic [pngse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pngse_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                q_full,
    output logic                                q_push,
    output pngse_pkg::item_t                    q_item,
    output pngse_pkg::geom_t                    geom
);

    localparam int CFG_MAX = (1 << pngse_pkg::CFG_W) - 1;
    localparam int EFF_MAX = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
    localparam int DIM_W   = $clog2(EFF_MAX + 1);
    localparam int RAW_W   = pngse_pkg::RAW_W;

    logic [pngse_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0]            col_reg, col_next;
    logic [DIM_W-1:0]            row_reg, row_next;
    logic                        hdr_sent_reg, hdr_sent_next;
    logic [RAW_W-1:0]            raw_reg, raw_next;
    logic [15:0]                 blocks_reg, blocks_next;
    logic [31:0]                 idat_reg, idat_next;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [DIM_W-1:0] c_cur, r_cur;
    logic [DIM_W:0]   c_inc, r_inc;
    logic             accept, done;
    logic             cfg_hit;
    logic [pngse_pkg::CFG_W+1:0] w_times4;
    logic [31:0]      bx;
    logic [15:0]      q0;
    logic [16:0]      rem;

    always_comb
    begin
        if (width_reg < pngse_pkg::CFG_W'(pngse_pkg::MIN_WIDTH))
        begin
            w_eff = DIM_W'(pngse_pkg::MIN_WIDTH);
        end
        else if (32'(width_reg) > 32'(EFF_MAX))
        begin
            w_eff = DIM_W'(EFF_MAX);
        end
        else
        begin
            w_eff = DIM_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (32'(height_reg) > 32'(EFF_MAX))
        begin
            h_eff = DIM_W'(EFF_MAX);
        end
        else
        begin
            h_eff = DIM_W'(height_reg);
        end
    end

    assign accept  = push && !q_full;
    assign cfg_hit = cfg_we && (cfg_index == pngse_pkg::REG_WIDTH ||
                                cfg_index == pngse_pkg::REG_HEIGHT);

    always_comb
    begin
        c_cur = hdr_sent_reg ? col_reg : '0;
        r_cur = hdr_sent_reg ? row_reg : '0;
        c_inc = (DIM_W+1)'(c_cur) + 1'b1;
        r_inc = (DIM_W+1)'(r_cur) + 1'b1;
        done  = 1'b0;
        col_next      = col_reg;
        row_next      = row_reg;
        hdr_sent_next = hdr_sent_reg;
        if (cfg_hit)
        begin
            col_next      = '0;
            row_next      = '0;
            hdr_sent_next = 1'b0;
        end
        else if (accept)
        begin
            if (c_inc >= (DIM_W+1)'(w_eff))
            begin
                col_next = '0;
                if (r_inc >= (DIM_W+1)'(h_eff))
                begin
                    done     = 1'b1;
                    row_next = '0;
                end
                else
                begin
                    row_next = r_inc[DIM_W-1:0];
                end
            end
            else
            begin
                col_next = c_inc[DIM_W-1:0];
                row_next = r_cur;
            end
            hdr_sent_next = !done;
        end
    end

    assign q_push       = accept;
    assign q_item.pixel = pixel;
    assign q_item.start = !hdr_sent_reg;
    assign q_item.col0  = (c_cur == '0);
    assign q_item.done  = done;

    // Geometry pipeline: raw_reg, then blocks_reg, then idat_reg settle in turn after a
    // register write, long before the back end reaches the IDAT length bytes.
    always_comb
    begin
        w_times4    = {pngse_pkg::CFG_W'(w_eff), 2'b01};
        raw_next    = RAW_W'(w_times4) * RAW_W'(h_eff);
        bx          = 32'(raw_reg) + 32'(pngse_pkg::BLOCK_MAX - 1);
        q0          = bx[31:16];
        rem         = 17'(bx[15:0]) + 17'(q0);
        blocks_next = q0 + ((rem >= 17'(pngse_pkg::BLOCK_MAX)) ? 16'd1 : 16'd0);
        idat_next   = 32'(raw_reg) + {14'd0, blocks_reg, 2'b00} + 32'(blocks_reg)
                      + 32'(pngse_pkg::IDAT_OVERHEAD);
    end

    assign geom.width    = pngse_pkg::CFG_W'(w_eff);
    assign geom.height   = pngse_pkg::CFG_W'(h_eff);
    assign geom.raw_len  = raw_reg;
    assign geom.idat_len = idat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= pngse_pkg::CFG_W'(pngse_pkg::MIN_WIDTH);
            height_reg   <= pngse_pkg::CFG_W'(1);
            col_reg      <= '0;
            row_reg      <= '0;
            hdr_sent_reg <= 1'b0;
            raw_reg      <= '0;
            blocks_reg   <= '0;
            idat_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == pngse_pkg::REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == pngse_pkg::REG_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            hdr_sent_reg <= hdr_sent_next;
            raw_reg      <= raw_next;
            blocks_reg   <= blocks_next;
            idat_reg     <= idat_next;
        end
    end

endmodule

FILE: rtl/core/pngse_back.sv
module pngse_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  pngse_pkg::item_t q_item,
    output logic             q_pop,
    input  pngse_pkg::geom_t geom,
    input  logic             out_full,
    output logic             out_push,
    output pngse_pkg::out_t  out_item
);

    localparam int RAW_W = pngse_pkg::RAW_W;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_SIG   = 10'b00_0000_0010,
        ST_IHDR  = 10'b00_0000_0100,
        ST_HCRC  = 10'b00_0000_1000,
        ST_IDATH = 10'b00_0001_0000,
        ST_DATA  = 10'b00_0010_0000,
        ST_ADLER = 10'b00_0100_0000,
        ST_DCRC  = 10'b00_1000_0000,
        ST_IEND  = 10'b01_0000_0000,
        ST_ECRC  = 10'b10_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [4:0]       idx_reg, idx_next;
    logic [2:0]       k_reg, k_next;
    logic [2:0]       bh_reg, bh_next;
    logic [31:0]      pix_reg, pix_next;
    logic             done_reg, done_next;
    logic [31:0]      crc_reg, crc_next;
    logic [15:0]      lo_reg, lo_next;
    logic [15:0]      hi_reg, hi_next;
    logic [15:0]      blk_reg, blk_next;
    logic [RAW_W-1:0] raw_reg, raw_next;

    logic        go, fin, crc_use, crc_init;
    logic [7:0]  byte_val;
    logic        last_b, eof_b;
    logic [31:0] raw32;
    logic [15:0] blk_len;
    logic        final_blk;
    logic [16:0] lo_sum, hi_sum;
    logic [15:0] lo_new;

    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] s);
        logic [7:0] b;
        case (s)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [31:0] crc_upd(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ pngse_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign go        = (state_reg != ST_IDLE) && !out_full;
    assign raw32     = 32'(raw_reg);
    assign final_blk = (raw32 <= 32'(pngse_pkg::BLOCK_MAX));
    assign blk_len   = final_blk ? raw32[15:0] : 16'(pngse_pkg::BLOCK_MAX);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        bh_next    = bh_reg;
        pix_next   = pix_reg;
        done_next  = done_reg;
        crc_next   = crc_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        blk_next   = blk_reg;
        raw_next   = raw_reg;
        byte_val   = '0;
        crc_use    = 1'b0;
        crc_init   = 1'b0;
        last_b     = 1'b0;
        eof_b      = 1'b0;
        fin        = 1'b0;
        q_pop      = 1'b0;
        lo_sum     = '0;
        hi_sum     = '0;
        lo_new     = '0;

        if (go)
        begin
            idx_next = idx_reg + 1'b1;
            case (state_reg)
                ST_SIG:
                begin
                    byte_val = pngse_pkg::SIG_BYTES[idx_reg[2:0]];
                    if (idx_reg == 5'd7)
                    begin
                        state_next = ST_IHDR;
                        idx_next   = '0;
                        raw_next   = geom.raw_len;
                        blk_next   = '0;
                        bh_next    = '0;
                        lo_next    = 16'd1;
                        hi_next    = '0;
                    end
                end
                ST_IHDR:
                begin
                    case (idx_reg) inside
                        [5'd0:5'd2]:  byte_val = '0;
                        5'd3:         byte_val = pngse_pkg::IHDR_LEN;
                        5'd4:         byte_val = pngse_pkg::CH_I;
                        5'd5:         byte_val = pngse_pkg::CH_H;
                        5'd6:         byte_val = pngse_pkg::CH_D;
                        5'd7:         byte_val = pngse_pkg::CH_R;
                        [5'd8:5'd11]: byte_val = be_byte(32'(geom.width), idx_reg[1:0]);
                        [5'd12:5'd15]: byte_val = be_byte(32'(geom.height), idx_reg[1:0]);
                        5'd16:        byte_val = pngse_pkg::BIT_DEPTH;
                        5'd17:        byte_val = pngse_pkg::COLOR_RGBA;
                        default:      byte_val = '0;
                    endcase
                    crc_use  = (idx_reg >= 5'd4);
                    crc_init = (idx_reg == 5'd4);
                    if (idx_reg == 5'd20)
                    begin
                        state_next = ST_HCRC;
                        idx_next   = '0;
                    end
                end
                ST_HCRC:
                begin
                    byte_val = be_byte(~crc_reg, idx_reg[1:0]);
                    if (idx_reg == 5'd3)
                    begin
                        state_next = ST_IDATH;
                        idx_next   = '0;
                    end
                end
                ST_IDATH:
                begin
                    case (idx_reg) inside
                        [5'd0:5'd3]: byte_val = be_byte(geom.idat_len, idx_reg[1:0]);
                        5'd4:        byte_val = pngse_pkg::CH_I;
                        5'd5:        byte_val = pngse_pkg::CH_D;
                        5'd6:        byte_val = pngse_pkg::CH_A;
                        5'd7:        byte_val = pngse_pkg::CH_T;
                        5'd8:        byte_val = pngse_pkg::ZLIB_CMF;
                        default:     byte_val = pngse_pkg::ZLIB_FLG;
                    endcase
                    crc_use  = (idx_reg >= 5'd4);
                    crc_init = (idx_reg == 5'd4);
                    if (idx_reg == 5'd9)
                    begin
                        state_next = ST_DATA;
                        idx_next   = '0;
                    end
                end
                ST_DATA:
                begin
                    crc_use = 1'b1;
                    if (blk_reg == '0)
                    begin
                        // Stored block header in front of the next data byte.
                        case (bh_reg)
                            3'd0:    byte_val = {7'd0, final_blk};
                            3'd1:    byte_val = blk_len[7:0];
                            3'd2:    byte_val = blk_len[15:8];
                            3'd3:    byte_val = ~blk_len[7:0];
                            default: byte_val = ~blk_len[15:8];
                        endcase
                        if (bh_reg == 3'd4)
                        begin
                            bh_next  = '0;
                            blk_next = blk_len;
                        end
                        else
                        begin
                            bh_next = bh_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        case (k_reg)
                            3'd1:    byte_val = pix_reg[7:0];
                            3'd2:    byte_val = pix_reg[15:8];
                            3'd3:    byte_val = pix_reg[23:16];
                            3'd4:    byte_val = pix_reg[31:24];
                            default: byte_val = '0;
                        endcase
                        lo_sum  = 17'(lo_reg) + 17'(byte_val);
                        lo_new  = (lo_sum >= 17'(pngse_pkg::ADLER_MOD))
                                  ? 16'(lo_sum - 17'(pngse_pkg::ADLER_MOD)) : lo_sum[15:0];
                        hi_sum  = 17'(hi_reg) + 17'(lo_new);
                        lo_next = lo_new;
                        hi_next = (hi_sum >= 17'(pngse_pkg::ADLER_MOD))
                                  ? 16'(hi_sum - 17'(pngse_pkg::ADLER_MOD)) : hi_sum[15:0];
                        blk_next = blk_reg - 1'b1;
                        if (raw_reg != '0)
                        begin
                            raw_next = raw_reg - 1'b1;
                        end
                        if (k_reg == 3'd4)
                        begin
                            if (done_reg)
                            begin
                                state_next = ST_ADLER;
                                idx_next   = '0;
                            end
                            else
                            begin
                                fin    = 1'b1;
                                last_b = 1'b1;
                            end
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                end
                ST_ADLER:
                begin
                    byte_val = be_byte({hi_reg, lo_reg}, idx_reg[1:0]);
                    crc_use  = 1'b1;
                    if (idx_reg == 5'd3)
                    begin
                        state_next = ST_DCRC;
                        idx_next   = '0;
                    end
                end
                ST_DCRC:
                begin
                    byte_val = be_byte(~crc_reg, idx_reg[1:0]);
                    if (idx_reg == 5'd3)
                    begin
                        state_next = ST_IEND;
                        idx_next   = '0;
                    end
                end
                ST_IEND:
                begin
                    case (idx_reg) inside
                        5'd4:    byte_val = pngse_pkg::CH_I;
                        5'd5:    byte_val = pngse_pkg::CH_E;
                        5'd6:    byte_val = pngse_pkg::CH_N;
                        5'd7:    byte_val = pngse_pkg::CH_D;
                        default: byte_val = '0;
                    endcase
                    crc_use  = (idx_reg >= 5'd4);
                    crc_init = (idx_reg == 5'd4);
                    if (idx_reg == 5'd7)
                    begin
                        state_next = ST_ECRC;
                        idx_next   = '0;
                    end
                end
                ST_ECRC:
                begin
                    byte_val = be_byte(~crc_reg, idx_reg[1:0]);
                    if (idx_reg == 5'd3)
                    begin
                        fin    = 1'b1;
                        last_b = 1'b1;
                        eof_b  = 1'b1;
                    end
                end
                default:
                begin
                    byte_val = '0;
                end
            endcase

            if (crc_use)
            begin
                crc_next = crc_upd(crc_init ? '1 : crc_reg, byte_val);
            end
            if (fin)
            begin
                state_next = ST_IDLE;
            end
        end

        // The next pixel is taken in the cycle its predecessor's last beat leaves.
        if ((state_reg == ST_IDLE || fin) && !q_empty)
        begin
            q_pop      = 1'b1;
            pix_next   = q_item.pixel;
            done_next  = q_item.done;
            k_next     = q_item.col0 ? 3'd0 : 3'd1;
            idx_next   = '0;
            state_next = q_item.start ? ST_SIG : ST_DATA;
        end
    end

    assign out_push      = go;
    assign out_item.data = byte_val;
    assign out_item.last = last_b;
    assign out_item.eof  = eof_b;

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            k_reg     <= '0;
            bh_reg    <= '0;
            done_reg  <= 1'b0;
            crc_reg   <= '1;
            lo_reg    <= 16'd1;
            hi_reg    <= '0;
            blk_reg   <= '0;
            raw_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            bh_reg    <= bh_next;
            done_reg  <= done_next;
            crc_reg   <= crc_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            blk_reg   <= blk_next;
            raw_reg   <= raw_next;
        end
    end

endmodule

FILE: rtl/core/png_stored_stream_encoder.sv
// A pixel's first beat reaches the result side through the item FIFO, the sequencer
// state registers and the output FIFO. The byte sequencer gives one beat per cycle
// while the output FIFO has room: 4 beats per pixel, 5 at a row start, 5 more at each
// stored-block boundary, 53 for the first pixel and 20 more for the last. The single
// byte lane sets the sustained pixel rate. Reset clears all control state, width to 2
// and height to 1; the geometry registers settle in turn after reset or a register write.
module png_stored_stream_encoder #(
    parameter int MAX_DIM    = pngse_pkg::DEF_MAX_DIM,
    parameter int ITEM_DEPTH = pngse_pkg::DEF_ITEM_DEPTH,
    parameter int OUT_DEPTH  = pngse_pkg::DEF_OUT_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [pngse_pkg::PIX_W-1:0]     pixel,
    output logic                            empty,
    input  logic                            pop,
    output logic [pngse_pkg::BYTE_W-1:0]    out_byte,
    output logic                            last_of_run,
    output logic                            end_of_file,
    input  logic                            cfg_we,
    input  logic [pngse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pngse_pkg::CFG_W-1:0]     cfg_data
);

    localparam int ITEM_W = $bits(pngse_pkg::item_t);
    localparam int OUT_W  = $bits(pngse_pkg::out_t);

    pngse_pkg::item_t  f_item, b_item;
    pngse_pkg::geom_t  geom;
    pngse_pkg::out_t   o_item, o_head;
    logic              q_push, q_full, q_pop, q_empty;
    logic              o_push, o_full;
    logic [ITEM_W-1:0] q_rdata;
    logic [OUT_W-1:0]  o_rdata;

    pngse_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pixel    (pixel),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (f_item),
        .geom     (geom)
    );

    pngse_fifo #(
        .WIDTH(ITEM_W),
        .DEPTH(ITEM_DEPTH)
    ) u_item_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .wdata(f_item),
        .full (q_full),
        .pop  (q_pop),
        .rdata(q_rdata),
        .empty(q_empty)
    );

    assign b_item = pngse_pkg::item_t'(q_rdata);
    assign full   = q_full;

    pngse_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (b_item),
        .q_pop   (q_pop),
        .geom    (geom),
        .out_full(o_full),
        .out_push(o_push),
        .out_item(o_item)
    );

    pngse_fifo #(
        .WIDTH(OUT_W),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (o_push),
        .wdata(o_item),
        .full (o_full),
        .pop  (pop),
        .rdata(o_rdata),
        .empty(empty)
    );

    assign o_head      = pngse_pkg::out_t'(o_rdata);
    assign out_byte    = o_head.data;
    assign last_of_run = o_head.last;
    assign end_of_file = o_head.eof;

endmodule
